>>> rtl/grfhm_pkg.sv
`default_nettype none

package grfhm_pkg;

  localparam int GRID_SIDE   = 511;
  localparam int COORD_W     = 9;
  localparam int HALF_W      = 8;
  localparam int VAL_W       = 8;
  localparam int HALF_MAX    = (GRID_SIDE - 1) / 2;
  localparam int HALF_RESET  = 200;
  localparam int CELL_DEPTH  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W      = $clog2(CELL_DEPTH);
  // walk coordinates run from one below zero to past the grid: sign plus one spare bit
  localparam int WC_W        = COORD_W + 2;
  localparam int DIST_W      = HALF_W;
  localparam int STEP_W      = DIST_W + 1;
  localparam int ACC_W       = STEP_W + DIST_W;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_RAY   = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_SPARE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_RUNAWAY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_WALK,
    S_DRAIN,
    S_FIN,
    S_RESP
  } state_t;

  typedef struct packed {
    logic lower_pend;
    logic at_end;
    logic over;
    logic in_grid;
  } walk_stat_t;

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] r,
                                                  input logic [COORD_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(GRID_SIDE) + ADDR_W'(c);
  endfunction

endpackage

`default_nettype wire

>>> rtl/grfhm_ram.sv
`default_nettype none

module grfhm_ram #(
  parameter int DEPTH = 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic              wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic              rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/grfhm_walk.sv
`default_nettype none

module grfhm_walk import grfhm_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               run,
  input  logic [HALF_W-1:0]  half,
  input  logic [COORD_W-1:0] side,
  input  logic [COORD_W-1:0] end_row,
  input  logic [COORD_W-1:0] end_col,
  output walk_stat_t         stat,
  output logic [COORD_W-1:0] cur_row,
  output logic [COORD_W-1:0] cur_col
);

  logic signed [WC_W-1:0] cr_r, cc_r, er_r, ec_r;
  logic [DIST_W-1:0]      ar_r, ac_r;
  logic                   neg_row_r, neg_col_r, lower_r;
  logic [STEP_W-1:0]      steps_r, limit_r;
  logic [ACC_W-1:0]       acc_row_r, acc_col_r;

  logic                   neg_row, neg_col, row_first, step;
  logic [COORD_W-1:0]     dist_row, dist_col;

  always_comb begin
    neg_row  = end_row < COORD_W'(half);
    neg_col  = end_col < COORD_W'(half);
    dist_row = neg_row ? COORD_W'(half) - end_row : end_row - COORD_W'(half);
    dist_col = neg_col ? COORD_W'(half) - end_col : end_col - COORD_W'(half);

    stat.lower_pend = lower_r;
    stat.at_end     = (cr_r == er_r) && (cc_r == ec_r);
    stat.over       = steps_r >= limit_r;
    stat.in_grid    = !cr_r[WC_W-1] && !cc_r[WC_W-1] &&
                      (cr_r[WC_W-2:0] < (WC_W-1)'(side)) &&
                      (cc_r[WC_W-2:0] < (WC_W-1)'(side));
    cur_row = cr_r[COORD_W-1:0];
    cur_col = cc_r[COORD_W-1:0];

    // exact form of the crossing test; column axis wins a tie
    row_first = (ar_r != '0) && ((ac_r == '0) || (acc_row_r < acc_col_r));
    step      = run && !lower_r && !stat.at_end && !stat.over;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_r <= 1'b0;
    end else if (start) begin
      lower_r <= neg_row | neg_col;
    end else if (run) begin
      lower_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      cr_r      <= WC_W'(half);
      cc_r      <= WC_W'(half);
      er_r      <= WC_W'(end_row);
      ec_r      <= WC_W'(end_col);
      ar_r      <= dist_row[DIST_W-1:0];
      ac_r      <= dist_col[DIST_W-1:0];
      neg_row_r <= neg_row;
      neg_col_r <= neg_col;
      steps_r   <= '0;
      limit_r   <= STEP_W'(dist_row[DIST_W-1:0]) + STEP_W'(dist_col[DIST_W-1:0]);
      acc_row_r <= ACC_W'(dist_col[DIST_W-1:0]);
      acc_col_r <= ACC_W'(dist_row[DIST_W-1:0]);
    end else if (run && lower_r) begin
      // step to the lower neighbor on each negative axis
      if (neg_row_r) begin
        cr_r <= cr_r - WC_W'(1);
      end
      if (neg_col_r) begin
        cc_r <= cc_r - WC_W'(1);
      end
    end else if (step) begin
      steps_r <= steps_r + STEP_W'(1);
      if (row_first) begin
        cr_r      <= neg_row_r ? cr_r - WC_W'(1) : cr_r + WC_W'(1);
        acc_row_r <= acc_row_r + ACC_W'(ac_r);
      end else begin
        cc_r      <= neg_col_r ? cc_r - WC_W'(1) : cc_r + WC_W'(1);
        acc_col_r <= acc_col_r + ACC_W'(ar_r);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/grid_ray_first_hit_marker_core.sv
`default_nettype none

// Channel   Direction  Handshake            Payload
// in_       slave      in_tvalid/in_tready  tuser: func; tdata: row, col, cell_value
// out_      master     out_tvalid/out_tready tuser: status; tdata: hit, hit_row, hit_col,
//                                           occupied, marked
// cfg_      write      cfg_wr_en            cfg_wr_data: half_range
//
// One item at a time; a ray walk stops at its end cell or on its step bound: the walk
// visits one cell per cycle through the occupancy memory read port.
// Synchronous active-low reset clears control only; grid cells are undefined until loaded.
// A new item is taken while the previous result waits in the output register.

module grid_ray_first_hit_marker_core import grfhm_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [1:0]             in_tuser,    // [1:0] func
  input  logic [IN_TDATA_W-1:0]  in_tdata,    // [8:0] row, [17:9] col, [25:18] cell_value
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [1:0]             out_tuser,   // [1:0] status
  output logic [OUT_TDATA_W-1:0] out_tdata,   // [0] hit, [9:1] hit_row, [18:10] hit_col,
                                              // [19] occupied, [20] marked
  input  logic                   cfg_wr_en,
  input  logic [HALF_W-1:0]      cfg_wr_data
);

  state_t             state_r, state_nxt;
  logic [HALF_W-1:0]  cfg_half_r, half;
  logic [COORD_W-1:0] side;

  logic [1:0]         item_func_r;
  logic [COORD_W-1:0] item_row_r, item_col_r;
  logic [VAL_W-1:0]   item_val_r;
  logic               item_oor;

  status_t            res_status_r;
  logic               res_hit_r, res_occ_r, res_mark_r;
  logic [COORD_W-1:0] res_row_r, res_col_r;

  logic               found_r, runaway_r, rd_pend_r;
  logic [COORD_W-1:0] fr_r, fc_r, rd_row_r, rd_col_r;

  logic                   out_tvalid_r;
  logic [1:0]             out_tuser_r;
  logic [OUT_TDATA_W-1:0] out_tdata_r;
  logic                   out_free;

  logic              occ_we, occ_wd, occ_re, occ_q;
  logic              mark_we, mark_wd, mark_re, mark_q;
  logic [ADDR_W-1:0] occ_waddr, occ_raddr, mark_waddr, item_addr;

  logic               walk_start, walk_run, ray_rd, walk_done;
  walk_stat_t         walk_stat;
  logic [COORD_W-1:0] walk_row, walk_col;

  always_comb begin
    half      = (cfg_half_r > HALF_W'(HALF_MAX)) ? HALF_W'(HALF_MAX) : cfg_half_r;
    side      = {half, 1'b1};
    item_oor  = (item_row_r >= side) || (item_col_r >= side);
    item_addr = cell_addr(item_row_r, item_col_r);
    out_free  = !out_tvalid_r || out_tready;
    walk_done = !walk_stat.lower_pend && (walk_stat.at_end || walk_stat.over);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (item_oor) begin
          state_nxt = S_RESP;
        end else begin
          case (item_func_r)
            FUNC_READ: state_nxt = S_RDWAIT;
            FUNC_RAY:  state_nxt = S_WALK;
            default:   state_nxt = S_RESP;
          endcase
        end
      end
      S_RDWAIT: state_nxt = S_RESP;
      S_WALK: begin
        if (walk_done) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: state_nxt = S_FIN;
      S_FIN:   state_nxt = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory and walk controls
  always_comb begin
    in_tready  = 1'b0;
    occ_we     = 1'b0;
    occ_wd     = 1'b0;
    occ_re     = 1'b0;
    mark_we    = 1'b0;
    mark_wd    = 1'b0;
    mark_re    = 1'b0;
    walk_start = 1'b0;
    walk_run   = 1'b0;
    ray_rd     = 1'b0;
    occ_waddr  = item_addr;
    occ_raddr  = item_addr;
    mark_waddr = item_addr;
    case (state_r)
      S_IDLE: in_tready = 1'b1;
      S_EXEC: begin
        case (item_func_r)
          FUNC_LOAD: begin
            occ_we  = !item_oor;
            occ_wd  = item_val_r == VAL_W'(1);
            mark_we = !item_oor;
          end
          FUNC_READ: begin
            occ_re  = !item_oor;
            mark_re = !item_oor;
          end
          FUNC_RAY: walk_start = !item_oor;
          default: ;
        endcase
      end
      S_WALK: begin
        walk_run  = 1'b1;
        ray_rd    = walk_stat.in_grid;
        occ_re    = walk_stat.in_grid;
        occ_raddr = cell_addr(walk_row, walk_col);
      end
      S_FIN: begin
        mark_we    = found_r && !runaway_r;
        mark_wd    = 1'b1;
        mark_waddr = cell_addr(fr_r, fc_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cfg_half_r <= HALF_W'(HALF_RESET);
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        cfg_half_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_func_r <= in_tuser;
      item_row_r  <= in_tdata[COORD_W-1:0];
      item_col_r  <= in_tdata[2*COORD_W-1:COORD_W];
      item_val_r  <= in_tdata[2*COORD_W+VAL_W-1:2*COORD_W];
    end
  end

  // resolve each ray read in the cycle after its issue; the first occupied cell wins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
      found_r   <= 1'b0;
      runaway_r <= 1'b0;
    end else begin
      rd_pend_r <= ray_rd;
      if (state_r == S_EXEC) begin
        found_r   <= 1'b0;
        runaway_r <= 1'b0;
      end else begin
        if (rd_pend_r && !found_r && occ_q) begin
          found_r <= 1'b1;
        end
        if (state_r == S_WALK && walk_done) begin
          runaway_r <= !walk_stat.at_end;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ray_rd) begin
      rd_row_r <= walk_row;
      rd_col_r <= walk_col;
    end
    if (rd_pend_r && !found_r && occ_q) begin
      fr_r <= rd_row_r;
      fc_r <= rd_col_r;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_EXEC: begin
        res_status_r <= (item_oor && item_func_r != FUNC_SPARE) ? ST_RANGE : ST_OK;
        res_hit_r    <= 1'b0;
        res_row_r    <= '0;
        res_col_r    <= '0;
        res_occ_r    <= 1'b0;
        res_mark_r   <= 1'b0;
      end
      S_RDWAIT: begin
        res_occ_r  <= occ_q;
        res_mark_r <= mark_q;
      end
      S_FIN: begin
        if (runaway_r) begin
          res_status_r <= ST_RUNAWAY;
        end else if (found_r) begin
          res_hit_r <= 1'b1;
          res_row_r <= fr_r;
          res_col_r <= fc_r;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == S_RESP && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_RESP && out_free) begin
      out_tuser_r <= res_status_r;
      out_tdata_r <= OUT_TDATA_W'({res_mark_r, res_occ_r, res_col_r, res_row_r, res_hit_r});
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

  grfhm_walk u_walk (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (walk_start),
    .run     (walk_run),
    .half    (half),
    .side    (side),
    .end_row (item_row_r),
    .end_col (item_col_r),
    .stat    (walk_stat),
    .cur_row (walk_row),
    .cur_col (walk_col)
  );

  grfhm_ram #(.DEPTH(CELL_DEPTH)) u_occ_ram (
    .clk   (clk),
    .we    (occ_we),
    .waddr (occ_waddr),
    .wdata (occ_wd),
    .re    (occ_re),
    .raddr (occ_raddr),
    .rdata (occ_q)
  );

  grfhm_ram #(.DEPTH(CELL_DEPTH)) u_mark_ram (
    .clk   (clk),
    .we    (mark_we),
    .waddr (mark_waddr),
    .wdata (mark_wd),
    .re    (mark_re),
    .raddr (item_addr),
    .rdata (mark_q)
  );

endmodule

`default_nettype wire
